// File: design/aeg_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// Holds payload structs, stage codes, register indexes and fixed-point sizes.
// No dependencies.
`timescale 1ns / 1ps

package aeg_pkg;

  // Fixed-point level format (Q1.15); width of a level and of the quotient
  localparam int LEVEL_FRAC_BITS = 15;
  localparam int LVL_W           = LEVEL_FRAC_BITS + 1;
  localparam logic [LVL_W-1:0] LEVEL_ONE = LVL_W'(1) << LEVEL_FRAC_BITS;

  // Shortest attack, decay or release time in microseconds
  localparam logic [31:0] MIN_TIME_US = 32'd1000;

  // Configuration bus
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_SUSTAIN = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_TRIGGER = 3'd4;
  localparam logic [2:0] REG_HOLD    = 3'd5;

  // Envelope stage codes
  localparam logic [2:0] STG_IDLE    = 3'd0;
  localparam logic [2:0] STG_ATTACK  = 3'd1;
  localparam logic [2:0] STG_DECAY   = 3'd2;
  localparam logic [2:0] STG_SUSTAIN = 3'd3;
  localparam logic [2:0] STG_RELEASE = 3'd4;

  typedef struct packed {
    logic        gate;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [15:0] env_level;
    logic [2:0]  env_stage;
  } out_item_t;

endpackage

// File: design/adsr_envelope_generator.sv
// ADSR envelope generator: one item per frame, one result item per input item.
// Sequence per item: update, evaluate, then, when a stage ramps, one 32x16
// multiply and a 16-step restoring divider, then finish; otherwise straight to finish.
// A new item is taken only once the sequencer is idle again; a result
// item held by the receiver stalls the input for as long.
// Reset (rst_ni low, asynchronous): configuration returns to defaults, stage
// idle, counters and level zero, no result pending.
`timescale 1ns / 1ps

module adsr_envelope_generator #(
  parameter int MAX_STEP_US     = 1000000,
  parameter int DEFAULT_STEP_US = 16000
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Frame input
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  aeg_pkg::in_item_t         in_item_i,
  // Result output
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output aeg_pkg::out_item_t        out_item_o,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [aeg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int LW      = aeg_pkg::LVL_W;
  localparam int STEP_MX = (MAX_STEP_US > DEFAULT_STEP_US) ? MAX_STEP_US : DEFAULT_STEP_US;
  localparam int STEP_W  = $clog2(STEP_MX + 1);
  localparam int CNT_W   = $clog2(LW);
  localparam int PROD_W  = 32 + LW;

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // Configuration registers
  logic [31:0]   attack_q, decay_q, release_q, hold_q;
  logic [15:0]   sustain_q;
  logic          trig_q;

  // Envelope state
  logic [2:0]    stage_q;
  logic [31:0]   stage_el_q, act_el_q, last_stamp_q;
  logic          gate_prev_q, seen_first_q;
  logic [LW-1:0] rel_from_q, level_q;

  // Sequencer
  logic [2:0]    seq_q;
  logic [CNT_W-1:0] cnt_q;
  logic          rise_q, fall_q;
  logic [STEP_W-1:0] step_q;

  // Shared multiply/divide datapath
  logic [31:0]   op_a_q, div_q, rem_q;
  logic [LW-1:0] op_b_q, num_lo_q, quo_q;
  logic          neg_q;

  // Output register
  logic          out_valid_q;
  aeg_pkg::out_item_t out_item_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:2])
      aeg_pkg::REG_ATTACK:  prdata = attack_q;
      aeg_pkg::REG_DECAY:   prdata = decay_q;
      aeg_pkg::REG_SUSTAIN: prdata = {16'd0, sustain_q};
      aeg_pkg::REG_RELEASE: prdata = release_q;
      aeg_pkg::REG_TRIGGER: prdata = {31'd0, trig_q};
      aeg_pkg::REG_HOLD:    prdata = hold_q;
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= 32'd10000;
      decay_q   <= 32'd100000;
      sustain_q <= 16'd22938;
      release_q <= 32'd300000;
      trig_q    <= 1'b0;
      hold_q    <= 32'd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        aeg_pkg::REG_ATTACK:  attack_q  <= pwdata;
        aeg_pkg::REG_DECAY:   decay_q   <= pwdata;
        aeg_pkg::REG_SUSTAIN: sustain_q <= pwdata[15:0];
        aeg_pkg::REG_RELEASE: release_q <= pwdata;
        aeg_pkg::REG_TRIGGER: trig_q    <= pwdata[0];
        aeg_pkg::REG_HOLD:    hold_q    <= pwdata;
        default: ;
      endcase
    end
  end

  // Floored stage times and clamped sustain level
  logic [31:0]   a_fl, d_fl, r_fl;
  logic [LW-1:0] s_cl;
  assign a_fl = (attack_q  < aeg_pkg::MIN_TIME_US) ? aeg_pkg::MIN_TIME_US : attack_q;
  assign d_fl = (decay_q   < aeg_pkg::MIN_TIME_US) ? aeg_pkg::MIN_TIME_US : decay_q;
  assign r_fl = (release_q < aeg_pkg::MIN_TIME_US) ? aeg_pkg::MIN_TIME_US : release_q;
  assign s_cl = (sustain_q > 16'(aeg_pkg::LEVEL_ONE)) ? aeg_pkg::LEVEL_ONE : LW'(sustain_q);

  // ---------------------------------------------------------------------------
  // Frame step at accept
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic [31:0]       prev_stamp, diff;
  logic [STEP_W-1:0] step_d;

  assign in_ready_o = (seq_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign prev_stamp = seen_first_q ? last_stamp_q : in_item_i.time_us;
  assign diff       = in_item_i.time_us - prev_stamp;
  assign step_d     = (diff[31] || diff > 32'(MAX_STEP_US)) ?
                      STEP_W'(DEFAULT_STEP_US) : diff[STEP_W-1:0];

  // ---------------------------------------------------------------------------
  // Stage transitions on gate and hold time, then advance the elapsed counters
  // ---------------------------------------------------------------------------
  logic [2:0]    upd_stage;
  logic [31:0]   upd_se, upd_ae;
  logic [LW-1:0] upd_rf;
  logic [32:0]   se_sum, ae_sum;

  always_comb begin
    upd_stage = stage_q;
    upd_se    = stage_el_q;
    upd_ae    = act_el_q;
    upd_rf    = rel_from_q;
    if (!trig_q) begin
      if (rise_q) begin
        upd_stage = aeg_pkg::STG_ATTACK;
        upd_se    = 32'd0;
        upd_rf    = level_q;
      end else if (fall_q && stage_q != aeg_pkg::STG_IDLE) begin
        upd_stage = aeg_pkg::STG_RELEASE;
        upd_se    = 32'd0;
        upd_rf    = level_q;
      end
    end else begin
      if (rise_q) begin
        upd_stage = aeg_pkg::STG_ATTACK;
        upd_se    = 32'd0;
        upd_ae    = 32'd0;
        upd_rf    = level_q;
      end
      if (upd_stage != aeg_pkg::STG_IDLE && upd_stage != aeg_pkg::STG_RELEASE &&
          hold_q != 32'd0 && upd_ae >= hold_q) begin
        upd_stage = aeg_pkg::STG_RELEASE;
        upd_se    = 32'd0;
        upd_rf    = level_q;
      end
    end
    // Saturating advance
    se_sum = {1'b0, upd_se} + 33'(step_q);
    ae_sum = {1'b0, upd_ae} + 33'(step_q);
    upd_se = se_sum[32] ? 32'hFFFF_FFFF : se_sum[31:0];
    if (upd_stage != aeg_pkg::STG_IDLE && upd_stage != aeg_pkg::STG_RELEASE) begin
      upd_ae = ae_sum[32] ? 32'hFFFF_FFFF : ae_sum[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Level evaluation: pick the ramp operands or a fixed level
  // ---------------------------------------------------------------------------
  logic [2:0]    ev_stage;
  logic          ev_clr, ev_ramp, ev_neg;
  logic [LW-1:0] ev_level, ev_op_b;
  logic [31:0]   ev_op_a, ev_div;

  always_comb begin
    ev_stage = stage_q;
    ev_clr   = 1'b0;
    ev_ramp  = 1'b0;
    ev_neg   = 1'b0;
    ev_level = '0;
    ev_op_a  = stage_el_q;
    ev_op_b  = aeg_pkg::LEVEL_ONE;
    ev_div   = a_fl;
    case (stage_q)
      aeg_pkg::STG_ATTACK: begin
        if (stage_el_q < a_fl) begin
          ev_ramp = 1'b1;
        end else begin
          ev_level = aeg_pkg::LEVEL_ONE;
          ev_stage = aeg_pkg::STG_DECAY;
          ev_clr   = 1'b1;
        end
      end
      aeg_pkg::STG_DECAY: begin
        ev_op_b = aeg_pkg::LEVEL_ONE - s_cl;
        ev_div  = d_fl;
        ev_neg  = 1'b1;
        if (stage_el_q < d_fl) begin
          ev_ramp = 1'b1;
        end else begin
          ev_level = s_cl;
          ev_stage = aeg_pkg::STG_SUSTAIN;
          ev_clr   = 1'b1;
        end
      end
      aeg_pkg::STG_SUSTAIN: ev_level = s_cl;
      aeg_pkg::STG_RELEASE: begin
        ev_op_a = r_fl - stage_el_q;
        ev_op_b = rel_from_q;
        ev_div  = r_fl;
        if (stage_el_q < r_fl) begin
          ev_ramp = 1'b1;
        end else begin
          ev_stage = aeg_pkg::STG_IDLE;
          ev_clr   = 1'b1;
        end
      end
      aeg_pkg::STG_IDLE: ev_level = '0;
      default: ev_stage = aeg_pkg::STG_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and one-bit-per-cycle restoring divider
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] prod;
  logic [32:0]       shifted, trial;
  logic              q_bit;
  logic [LW-1:0]     quo_next, div_level;

  assign prod      = op_a_q * op_b_q;
  assign shifted   = {rem_q, num_lo_q[LW-1]};
  assign trial     = shifted - {1'b0, div_q};
  assign q_bit     = ~trial[32];
  assign quo_next  = {quo_q[LW-2:0], q_bit};
  assign div_level = neg_q ? (aeg_pkg::LEVEL_ONE - quo_next) : quo_next;

  always_ff @(posedge clk_i) begin
    // Load operands for the ramp
    if (seq_q == S_EVAL) begin
      op_a_q <= ev_op_a;
      op_b_q <= ev_op_b;
      div_q  <= ev_div;
      neg_q  <= ev_neg;
    end
    // Register the product; its upper part already lies below the divisor
    if (seq_q == S_MUL) begin
      rem_q    <= prod[PROD_W-1:LW];
      num_lo_q <= prod[LW-1:0];
    end
    // Shift one quotient bit in per cycle
    if (seq_q == S_DIV) begin
      rem_q    <= q_bit ? trial[31:0] : shifted[31:0];
      num_lo_q <= num_lo_q << 1;
      quo_q    <= quo_next;
    end
    // Capture the result item
    if (seq_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      out_item_q.env_level <= level_q;
      out_item_q.env_stage <= stage_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and envelope state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= S_IDLE;
      cnt_q        <= '0;
      rise_q       <= 1'b0;
      fall_q       <= 1'b0;
      step_q       <= '0;
      stage_q      <= aeg_pkg::STG_IDLE;
      stage_el_q   <= 32'd0;
      act_el_q     <= 32'd0;
      gate_prev_q  <= 1'b0;
      rel_from_q   <= '0;
      level_q      <= '0;
      last_stamp_q <= 32'd0;
      seen_first_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (seq_q)
        S_IDLE: begin
          if (in_acc) begin
            rise_q       <= in_item_i.gate & ~gate_prev_q;
            fall_q       <= ~in_item_i.gate & gate_prev_q;
            gate_prev_q  <= in_item_i.gate;
            last_stamp_q <= in_item_i.time_us;
            seen_first_q <= 1'b1;
            step_q       <= step_d;
            seq_q        <= S_UPD;
          end
        end
        S_UPD: begin
          stage_q    <= upd_stage;
          stage_el_q <= upd_se;
          act_el_q   <= upd_ae;
          rel_from_q <= upd_rf;
          seq_q      <= S_EVAL;
        end
        S_EVAL: begin
          stage_q <= ev_stage;
          if (ev_clr) begin
            stage_el_q <= 32'd0;
          end
          if (ev_ramp) begin
            seq_q <= S_MUL;
          end else begin
            level_q <= ev_level;
            seq_q   <= S_FIN;
          end
        end
        S_MUL: begin
          cnt_q <= '0;
          seq_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(LW - 1)) begin
            level_q <= div_level;
            seq_q   <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            seq_q       <= S_IDLE;
          end
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: design/aeg_checker.sv
// Port-level assertions for the ADSR envelope generator.
// Depends on aeg_pkg; bound to adsr_envelope_generator below.
`timescale 1ns / 1ps

module aeg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input aeg_pkg::out_item_t out_item_o
);

  // A pending result item stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  // One item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // Level stays within 0..1.0 and the stage code is defined
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.env_level <= 16'(aeg_pkg::LEVEL_ONE)) &&
                    (out_item_o.env_stage <= aeg_pkg::STG_RELEASE))
    else $error("result item out of range");

  // Idle means silence
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.env_stage == aeg_pkg::STG_IDLE |->
      out_item_o.env_level == 16'd0)
    else $error("idle stage with nonzero level");

  // Attack ramps below full scale
  a_attack_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.env_stage == aeg_pkg::STG_ATTACK |->
      out_item_o.env_level < 16'(aeg_pkg::LEVEL_ONE))
    else $error("attack level reached full scale");

endmodule

bind adsr_envelope_generator aeg_checker u_aeg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
